>>> src/rsi_pkg.sv
// Shared widths, constants and pipeline payload types for the ray-sphere intersection unit.
`timescale 1ns / 1ps
package rsi_pkg;

  // Field widths of the channels.
  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadiusW = 31;

  // Fixed-point fraction positions.
  localparam int unsigned Frac    = 16;
  localparam int unsigned DirFrac = 30;

  // Internal widths, sized so that nothing wraps for any input pattern.
  localparam int unsigned ProdW   = 2 * CoordW;
  localparam int unsigned RrFullW = 2 * RadiusW;
  localparam int unsigned RrW     = RrFullW - Frac;
  localparam int unsigned BW      = 36;
  localparam int unsigned SdW     = CoordW + BW;
  localparam int unsigned InnerW  = 39;
  localparam int unsigned MagW    = 37;
  localparam int unsigned MhW     = MagW - Frac;
  localparam int unsigned HhW     = 2 * MhW;
  localparam int unsigned HlW     = MhW + Frac;
  localparam int unsigned LlW     = 2 * Frac;
  localparam int unsigned IsqW    = 60;
  localparam int unsigned CmW     = 48;
  localparam int unsigned CW      = CmW + 1;
  localparam int unsigned RadW    = RrW + Frac;
  localparam int unsigned RootW   = RadW / 2;
  localparam int unsigned QW      = 38;
  localparam int unsigned QmW     = QW - 1;
  localparam int unsigned QuotW   = 41;
  localparam int unsigned NumHiW  = CmW + Frac - QuotW;
  localparam int unsigned TW      = QuotW + 1;

  // Reset value of the radius register: 1.0 in unsigned Q15.16.
  localparam logic [RadiusW-1:0] RadiusReset = 31'd65536;

  // Quotient cap of 2^40 and the Q16.16 rails.
  localparam logic [QuotW-1:0] QuotCap = {1'b1, {(QuotW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] DistMax = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] DistMin = 32'sh8000_0000;

  // Payload carried alongside the square-root cells.
  typedef struct packed {
    logic                 miss;
    logic signed [BW-1:0] b;
    logic signed [CW-1:0] c;
  } sqrt_side_t;

  // Payload carried alongside the divider cells.
  typedef struct packed {
    logic                 miss;
    logic                 ovf;
    logic                 neg;
    logic signed [QW-1:0] q;
  } div_side_t;

  // One result item.
  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] hit_dist;
    logic                     sat;
  } result_t;

endpackage

>>> src/rsi_channel_if.sv
// Valid/ready channel interfaces for rays, results and the radius write port.
`timescale 1ns / 1ps
interface rsi_ray_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsi_pkg::CoordW-1:0] origin_x;
  logic signed [rsi_pkg::CoordW-1:0] origin_y;
  logic signed [rsi_pkg::CoordW-1:0] origin_z;
  logic signed [rsi_pkg::CoordW-1:0] dir_x;
  logic signed [rsi_pkg::CoordW-1:0] dir_y;
  logic signed [rsi_pkg::CoordW-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rsi_hit_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic signed [rsi_pkg::CoordW-1:0] hit_distance;
  logic                              saturated;

  modport source (output valid, hit, hit_distance, saturated, input ready);
  modport sink (input valid, hit, hit_distance, saturated, output ready);
endinterface

interface rsi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rsi_pkg::RadiusW-1:0]   sphere_radius;

  modport source (output valid, sphere_radius, input ready);
  modport sink (input valid, sphere_radius, output ready);
endinterface

>>> src/ray_sphere_intersection_unit.sv
// Top level of the ray-sphere intersection unit: front pipeline, root and divider chains.
//
// Usage. Rays enter on in_ray (origin Q16.16, unit direction Q1.30) with a
// valid/ready handshake; one result per ray leaves on out_hit in request order:
// hit, distance t in Q16.16 and a saturation flag. The radius (unsigned
// Q15.16) is written on cfg_wr, which is always ready; write it while no ray
// is in flight.
// The path from request acceptance to out_hit.valid runs through 7 front
// stages, 31 square-root cells (one root bit each), 2 stages that form q and
// the divider operands, and 41 divider cells (one quotient bit each), then
// the output register.
// Throughput: one ray per cycle while the skid buffer is free; every stage
// and cell takes a new request each cycle that the pipeline advances.
// Stalls: the output register is backed by a one-entry skid buffer. While a
// result waits, the pipeline keeps advancing; only when the skid buffer also
// holds a result does in_ray.ready drop and the whole pipeline freeze.
// Reset: synchronous rst_n empties the pipeline and output, and loads the
// radius with 1.0.
`timescale 1ns / 1ps
module ray_sphere_intersection_unit (
  input  logic      clk,
  input  logic      rst_n,
  rsi_cfg_if.sink   cfg_wr,
  rsi_ray_if.sink   in_ray,
  rsi_hit_if.source out_hit
);
  import rsi_pkg::*;

  logic               pipe_en;
  logic [RadiusW-1:0] radius_r;

  logic signed [CoordW-1:0] org_w [3];
  logic signed [CoordW-1:0] dir_w [3];

  // Square-root chain links.
  logic            sq_vld_w  [RootW+1];
  sqrt_side_t      sq_side_w [RootW+1];
  logic [RadW-1:0] sq_v_w    [RootW+1];
  logic [RadW-1:0] sq_res_w  [RootW+1];

  // Stage forming q.
  logic [RootW-1:0]     root_w;
  logic signed [QW-1:0] bq_w;
  logic signed [QW-1:0] sroot_w;
  logic signed [QW-1:0] q_nxt;
  logic                 qs_v_r;
  logic signed [QW-1:0] qs_q_r;
  logic signed [CW-1:0] qs_c_r;
  logic                 qs_miss_r;

  // Stage preparing the divider operands.
  logic [QmW-1:0]    qm_w;
  logic [CmW-1:0]    cm_w;
  logic [NumHiW-1:0] num_hi_w;
  div_side_t         pr_side_nxt;
  logic              pr_v_r;
  div_side_t         pr_side_r;
  logic [QmW-1:0]    pr_dvs_r;
  logic [QmW-1:0]    pr_rem_r;
  logic [QuotW-1:0]  pr_num_r;

  // Divider chain links.
  logic             dv_vld_w  [QuotW+1];
  div_side_t        dv_side_w [QuotW+1];
  logic [QmW-1:0]   dv_dvs_w  [QuotW+1];
  logic [QmW-1:0]   dv_rem_w  [QuotW+1];
  logic [QuotW-1:0] dv_num_w  [QuotW+1];
  logic [QuotW-1:0] dv_quo_w  [QuotW+1];

  // Final selection and output buffering.
  div_side_t            fin_side_w;
  logic [QuotW-1:0]     mag_w;
  logic signed [TW-1:0] t0_w;
  logic signed [TW-1:0] qx_w;
  logic signed [TW-1:0] t_w;
  result_t              res_w;
  logic                 leave_w;
  logic                 out_take_w;
  logic                 out_v_r;
  result_t              out_r;
  logic                 skid_v_r;
  result_t              skid_r;

  // Radius register; the port never stalls.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RadiusReset;
    end else if (cfg_wr.valid) begin
      radius_r <= cfg_wr.sphere_radius;
    end
  end

  // The pipeline moves whenever the skid buffer is free.
  assign pipe_en      = !skid_v_r;
  assign in_ray.ready = pipe_en;

  assign org_w[0] = in_ray.origin_x;
  assign org_w[1] = in_ray.origin_y;
  assign org_w[2] = in_ray.origin_z;
  assign dir_w[0] = in_ray.dir_x;
  assign dir_w[1] = in_ray.dir_y;
  assign dir_w[2] = in_ray.dir_z;

  rsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .vld_i    (in_ray.valid),
    .org_i    (org_w),
    .dir_i    (dir_w),
    .radius_i (radius_r),
    .vld_o    (sq_vld_w[0]),
    .side_o   (sq_side_w[0]),
    .rad_o    (sq_v_w[0])
  );

  assign sq_res_w[0] = '0;

  // Square-root chain, most significant root bit first.
  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    rsi_sqrt_cell #(
      .Step (RootW - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (pipe_en),
      .vld_i  (sq_vld_w[k]),
      .side_i (sq_side_w[k]),
      .v_i    (sq_v_w[k]),
      .res_i  (sq_res_w[k]),
      .vld_o  (sq_vld_w[k+1]),
      .side_o (sq_side_w[k+1]),
      .v_o    (sq_v_w[k+1]),
      .res_o  (sq_res_w[k+1])
    );
  end

  // q = -b - sqrt when b is not negative, else -b + sqrt.
  always_comb begin
    root_w  = sq_res_w[RootW][RootW-1:0];
    bq_w    = QW'(sq_side_w[RootW].b);
    sroot_w = QW'({1'b0, root_w});
    q_nxt   = bq_w[QW-1] ? sroot_w - bq_w : -bq_w - sroot_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_v_r <= 1'b0;
      pr_v_r <= 1'b0;
    end else if (pipe_en) begin
      qs_v_r <= sq_vld_w[RootW];
      pr_v_r <= qs_v_r;
    end
  end

  // Magnitudes, numerator split and quotient overflow check.
  always_comb begin
    qm_w     = qs_q_r[QW-1] ? QmW'(-qs_q_r) : QmW'(qs_q_r);
    cm_w     = qs_c_r[CW-1] ? CmW'(-qs_c_r) : CmW'(qs_c_r);
    num_hi_w = cm_w[CmW-1:CmW-NumHiW];
    pr_side_nxt.miss = qs_miss_r || (qs_q_r == '0);
    pr_side_nxt.ovf  = QmW'(num_hi_w) >= qm_w;
    pr_side_nxt.neg  = qs_c_r[CW-1] ^ qs_q_r[QW-1];
    pr_side_nxt.q    = qs_q_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      qs_q_r    <= q_nxt;
      qs_c_r    <= sq_side_w[RootW].c;
      qs_miss_r <= sq_side_w[RootW].miss;
      pr_side_r <= pr_side_nxt;
      pr_dvs_r  <= qm_w;
      pr_rem_r  <= pr_side_nxt.ovf ? '0 : QmW'(num_hi_w);
      pr_num_r  <= {cm_w[CmW-NumHiW-1:0], {Frac{1'b0}}};
    end
  end

  assign dv_vld_w[0]  = pr_v_r;
  assign dv_side_w[0] = pr_side_r;
  assign dv_dvs_w[0]  = pr_dvs_r;
  assign dv_rem_w[0]  = pr_rem_r;
  assign dv_num_w[0]  = pr_num_r;
  assign dv_quo_w[0]  = '0;

  // Divider chain, most significant quotient bit first.
  for (genvar k = 0; k < QuotW; k++) begin : g_div
    rsi_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (pipe_en),
      .vld_i  (dv_vld_w[k]),
      .side_i (dv_side_w[k]),
      .dvs_i  (dv_dvs_w[k]),
      .rem_i  (dv_rem_w[k]),
      .num_i  (dv_num_w[k]),
      .quo_i  (dv_quo_w[k]),
      .vld_o  (dv_vld_w[k+1]),
      .side_o (dv_side_w[k+1]),
      .dvs_o  (dv_dvs_w[k+1]),
      .rem_o  (dv_rem_w[k+1]),
      .num_o  (dv_num_w[k+1]),
      .quo_o  (dv_quo_w[k+1])
    );
  end

  // Cap the quotient, apply its sign, take the minimum with q and clamp.
  always_comb begin
    fin_side_w = dv_side_w[QuotW];
    mag_w = (fin_side_w.ovf || dv_quo_w[QuotW] > QuotCap) ? QuotCap : dv_quo_w[QuotW];
    t0_w  = TW'($signed({1'b0, mag_w}));
    if (fin_side_w.neg) begin
      t0_w = -t0_w;
    end
    qx_w = TW'(fin_side_w.q);
    t_w  = (t0_w < qx_w) ? t0_w : qx_w;
    res_w.hit      = 1'b1;
    res_w.sat      = 1'b0;
    res_w.hit_dist = t_w[CoordW-1:0];
    if (t_w > TW'(DistMax)) begin
      res_w.sat      = 1'b1;
      res_w.hit_dist = DistMax;
    end else if (t_w < TW'(DistMin)) begin
      res_w.sat      = 1'b1;
      res_w.hit_dist = DistMin;
    end
    if (fin_side_w.miss) begin
      res_w = '0;
    end
  end

  assign leave_w    = pipe_en && dv_vld_w[QuotW];
  assign out_take_w = out_v_r && out_hit.ready;

  // Output register and skid buffer valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take_w) begin
        skid_v_r <= 1'b0;
      end
    end else if (leave_w) begin
      if (out_v_r && !out_take_w) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_take_w) begin
      out_v_r <= 1'b0;
    end
  end

  // Output register and skid buffer payload.
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take_w) begin
        out_r <= skid_r;
      end
    end else if (leave_w) begin
      if (out_v_r && !out_take_w) begin
        skid_r <= res_w;
      end else begin
        out_r <= res_w;
      end
    end
  end

  assign out_hit.valid        = out_v_r;
  assign out_hit.hit          = out_r.hit;
  assign out_hit.hit_distance = out_r.hit_dist;
  assign out_hit.saturated    = out_r.sat;

  // The skid buffer only ever holds a result behind a waiting one.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid buffer full while output register empty");

  // The skid buffer fills only when the receiver stalls a waiting result.
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_hit.ready))
    else $error("skid buffer filled without an output stall");

  // A miss carries zero distance and no saturation.
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.hit |-> out_r.hit_dist == '0 && !out_r.sat)
    else $error("miss result with nonzero fields");

  // A saturated distance sits on one of the Q16.16 rails.
  a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.sat |-> out_r.hit_dist == DistMax || out_r.hit_dist == DistMin)
    else $error("saturated distance off the rails");

endmodule

>>> src/rsi_front.sv
// Front pipeline: dot product, perpendicular distance squared, |o|^2 and r^2.
`timescale 1ns / 1ps
module rsi_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  logic signed [rsi_pkg::CoordW-1:0] org_i [3],
  input  logic signed [rsi_pkg::CoordW-1:0] dir_i [3],
  input  logic [rsi_pkg::RadiusW-1:0]       radius_i,
  output logic                              vld_o,
  output rsi_pkg::sqrt_side_t               side_o,
  output logic [rsi_pkg::RadW-1:0]          rad_o
);
  import rsi_pkg::*;

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] vld_r;

  // Stage 1: products o*d, o*o and r*r.
  logic signed [CoordW-1:0]  o1_r [3];
  logic signed [CoordW-1:0]  d1_r [3];
  logic signed [ProdW-1:0]   od1_r [3];
  logic signed [ProdW-1:0]   od1_nxt [3];
  logic signed [ProdW-1:0]   oo1_r [3];
  logic signed [ProdW-1:0]   oo1_nxt [3];
  logic [RrFullW-1:0]        rr1_r;
  logic [RrFullW-1:0]        rr1_nxt;

  // Stage 2: b and the sums of squares.
  logic signed [CoordW-1:0]  o2_r [3];
  logic signed [CoordW-1:0]  d2_r [3];
  logic signed [BW-1:0]      b2_r;
  logic signed [BW-1:0]      b2_nxt;
  logic [CmW-1:0]            osq2_r;
  logic [CmW-1:0]            osq2_nxt;
  logic [RrW-1:0]            rr2_r;

  // Stage 3: d*b.
  logic signed [CoordW-1:0]  o3_r [3];
  logic signed [SdW-1:0]     sd3_r [3];
  logic signed [SdW-1:0]     sd3_nxt [3];
  logic signed [BW-1:0]      b3_r;
  logic [CmW-1:0]            osq3_r;
  logic [RrW-1:0]            rr3_r;

  // Stage 4: magnitude of o - s.
  logic signed [InnerW-1:0]  inner_w [3];
  logic [InnerW-1:0]         mag_w [3];
  logic [MagW-1:0]           m4_r [3];
  logic signed [BW-1:0]      b4_r;
  logic [CmW-1:0]            osq4_r;
  logic [RrW-1:0]            rr4_r;

  // Stage 5: partial products of the square.
  logic [MhW-1:0]            mh_w [3];
  logic [Frac-1:0]           ml_w [3];
  logic [HhW-1:0]            hh5_r [3];
  logic [HhW-1:0]            hh5_nxt [3];
  logic [HlW-1:0]            hl5_r [3];
  logic [HlW-1:0]            hl5_nxt [3];
  logic [LlW-1:0]            ll5_r [3];
  logic [LlW-1:0]            ll5_nxt [3];
  logic signed [BW-1:0]      b5_r;
  logic [CmW-1:0]            osq5_r;
  logic [RrW-1:0]            rr5_r;

  // Stage 6: sum of squared perpendicular components.
  logic [IsqW-1:0]           isq6_r;
  logic [IsqW-1:0]           isq6_nxt;
  logic signed [BW-1:0]      b6_r;
  logic [CmW-1:0]            osq6_r;
  logic [RrW-1:0]            rr6_r;

  // Stage 7: discriminant, radicand and c.
  sqrt_side_t                side7_r;
  sqrt_side_t                side7_nxt;
  logic [RadW-1:0]           rad7_r;
  logic [RadW-1:0]           rad7_nxt;
  logic [RrW-1:0]            disc_w;

  // Arithmetic of every stage.
  always_comb begin
    b2_nxt   = '0;
    osq2_nxt = '0;
    isq6_nxt = '0;
    rr1_nxt  = RrFullW'(radius_i) * RrFullW'(radius_i);
    for (int i = 0; i < 3; i++) begin
      od1_nxt[i] = org_i[i] * dir_i[i];
      oo1_nxt[i] = org_i[i] * org_i[i];
      b2_nxt     = b2_nxt + BW'($signed(od1_r[i][ProdW-1:DirFrac]));
      osq2_nxt   = osq2_nxt + CmW'(oo1_r[i][ProdW-2:Frac]);
      sd3_nxt[i] = d2_r[i] * b2_r;
      inner_w[i] = InnerW'(o3_r[i]) - InnerW'($signed(sd3_r[i][SdW-1:DirFrac]));
      mag_w[i]   = inner_w[i][InnerW-1] ? InnerW'(-inner_w[i]) : InnerW'(inner_w[i]);
      mh_w[i]    = m4_r[i][MagW-1:Frac];
      ml_w[i]    = m4_r[i][Frac-1:0];
      hh5_nxt[i] = HhW'(mh_w[i]) * HhW'(mh_w[i]);
      hl5_nxt[i] = HlW'(mh_w[i]) * HlW'(ml_w[i]);
      ll5_nxt[i] = LlW'(ml_w[i]) * LlW'(ml_w[i]);
      isq6_nxt   = isq6_nxt + (IsqW'(hh5_r[i]) << Frac) + (IsqW'(hl5_r[i]) << 1)
                   + IsqW'(ll5_r[i][LlW-1:Frac]);
    end
    disc_w         = rr6_r - isq6_r[RrW-1:0];
    rad7_nxt       = {disc_w, {Frac{1'b0}}};
    side7_nxt.miss = isq6_r > IsqW'(rr6_r);
    side7_nxt.b    = b6_r;
    side7_nxt.c    = $signed(CW'(osq6_r)) - $signed(CW'(rr6_r));
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Stages-2:0], vld_i};
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o1_r[i]  <= org_i[i];
        d1_r[i]  <= dir_i[i];
        od1_r[i] <= od1_nxt[i];
        oo1_r[i] <= oo1_nxt[i];
        o2_r[i]  <= o1_r[i];
        d2_r[i]  <= d1_r[i];
        o3_r[i]  <= o2_r[i];
        sd3_r[i] <= sd3_nxt[i];
        m4_r[i]  <= mag_w[i][MagW-1:0];
        hh5_r[i] <= hh5_nxt[i];
        hl5_r[i] <= hl5_nxt[i];
        ll5_r[i] <= ll5_nxt[i];
      end
      rr1_r   <= rr1_nxt;
      b2_r    <= b2_nxt;
      osq2_r  <= osq2_nxt;
      rr2_r   <= rr1_r[RrFullW-1:Frac];
      b3_r    <= b2_r;
      osq3_r  <= osq2_r;
      rr3_r   <= rr2_r;
      b4_r    <= b3_r;
      osq4_r  <= osq3_r;
      rr4_r   <= rr3_r;
      b5_r    <= b4_r;
      osq5_r  <= osq4_r;
      rr5_r   <= rr4_r;
      isq6_r  <= isq6_nxt;
      b6_r    <= b5_r;
      osq6_r  <= osq5_r;
      rr6_r   <= rr5_r;
      side7_r <= side7_nxt;
      rad7_r  <= rad7_nxt;
    end
  end

  assign vld_o  = vld_r[Stages-1];
  assign side_o = side7_r;
  assign rad_o  = rad7_r;

endmodule

>>> src/rsi_sqrt_cell.sv
// One cell of the square-root chain: settles one bit of the root per cycle while en is high.
`timescale 1ns / 1ps
module rsi_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  rsi_pkg::sqrt_side_t      side_i,
  input  logic [rsi_pkg::RadW-1:0] v_i,
  input  logic [rsi_pkg::RadW-1:0] res_i,
  output logic                     vld_o,
  output rsi_pkg::sqrt_side_t      side_o,
  output logic [rsi_pkg::RadW-1:0] v_o,
  output logic [rsi_pkg::RadW-1:0] res_o
);
  import rsi_pkg::*;

  localparam logic [RadW:0] StepBit = {{RadW{1'b0}}, 1'b1} << (2 * Step);

  logic [RadW:0]   trial_w;
  logic            take_w;
  logic            vld_r;
  sqrt_side_t      side_r;
  logic [RadW-1:0] v_r;
  logic [RadW-1:0] v_nxt;
  logic [RadW-1:0] res_r;
  logic [RadW-1:0] res_nxt;

  // Try to subtract the current trial square from the remainder.
  always_comb begin
    trial_w = {1'b0, res_i} + StepBit;
    take_w  = {1'b0, v_i} >= trial_w;
    if (take_w) begin
      v_nxt   = v_i - trial_w[RadW-1:0];
      res_nxt = (res_i >> 1) + StepBit[RadW-1:0];
    end else begin
      v_nxt   = v_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      v_r    <= v_nxt;
      res_r  <= res_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign v_o    = v_r;
  assign res_o  = res_r;

endmodule

>>> src/rsi_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit per cycle while en is high.
`timescale 1ns / 1ps
module rsi_div_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_i,
  input  rsi_pkg::div_side_t        side_i,
  input  logic [rsi_pkg::QmW-1:0]   dvs_i,
  input  logic [rsi_pkg::QmW-1:0]   rem_i,
  input  logic [rsi_pkg::QuotW-1:0] num_i,
  input  logic [rsi_pkg::QuotW-1:0] quo_i,
  output logic                      vld_o,
  output rsi_pkg::div_side_t        side_o,
  output logic [rsi_pkg::QmW-1:0]   dvs_o,
  output logic [rsi_pkg::QmW-1:0]   rem_o,
  output logic [rsi_pkg::QuotW-1:0] num_o,
  output logic [rsi_pkg::QuotW-1:0] quo_o
);
  import rsi_pkg::*;

  logic [QmW:0]     rem2_w;
  logic             take_w;
  logic [QmW:0]     diff_w;
  logic             vld_r;
  div_side_t        side_r;
  logic [QmW-1:0]   dvs_r;
  logic [QmW-1:0]   rem_r;
  logic [QmW-1:0]   rem_nxt;
  logic [QuotW-1:0] num_r;
  logic [QuotW-1:0] quo_r;

  // Bring down the next numerator bit and subtract the divisor if it fits.
  always_comb begin
    rem2_w  = {rem_i, num_i[QuotW-1]};
    take_w  = rem2_w >= {1'b0, dvs_i};
    diff_w  = rem2_w - {1'b0, dvs_i};
    rem_nxt = take_w ? diff_w[QmW-1:0] : rem2_w[QmW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      dvs_r  <= dvs_i;
      rem_r  <= rem_nxt;
      num_r  <= {num_i[QuotW-2:0], 1'b0};
      quo_r  <= {quo_i[QuotW-2:0], take_w};
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign dvs_o  = dvs_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign quo_o  = quo_r;

endmodule
